// ===== rtl/bfu_pkg.sv =====
// ----------------------------------------------------------------------------
// bfu_pkg: shared definitions for the bit-field unpacker
// Widths, register indexes and the element width limit used by the
// channel interfaces and the unpacker core.
// ----------------------------------------------------------------------------
package bfu_pkg;

  // Largest element width the build supports (W_CAP caps it at 32); results stay 32 bits
  localparam int MAX_WIDTH = 32;
  localparam int W_CAP     = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;

  // Field and register widths
  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 32;
  localparam int WIDTH_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = WIDTH_W;

  // Accumulator: fewer than W_CAP bits left over plus one new byte
  localparam int ACC_W = W_CAP - 1 + BYTE_W;

  // Width register reset value
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(8);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEMENT_WIDTH = 2'd0,
    REG_SIGN_EXT      = 2'd1
  } cfg_reg_t;

endpackage

// ===== rtl/bfu_if.sv =====
// ----------------------------------------------------------------------------
// bfu_if: channel interfaces of the bit-field unpacker
// Byte input channel and element output channel, each with valid/ready.
// ----------------------------------------------------------------------------
interface bfu_byte_if import bfu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface bfu_elem_if import bfu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] element_value;
  logic                      last_of_byte;

  modport source (output valid, output element_value, output last_of_byte, input ready);
  modport sink   (input valid, input element_value, input last_of_byte, output ready);
endinterface

// ===== rtl/bit_field_unpacker_core.sv =====
// ----------------------------------------------------------------------------
// bit_field_unpacker_core: LSB-first bit-field unpacker
// Cuts elements of a configured width from a byte stream, bit 0 first, and
// returns each one zero- or sign-extended to a 32-bit word.
// ----------------------------------------------------------------------------
// Usage:
//   in_byte  carries one buffer byte per transaction; end_of_buffer marks the
//            final byte, after whose elements leftover bits are dropped.
//   out_elem carries one element per transaction; last_of_byte marks the last
//            element completed by a byte. A byte that completes no element
//            gives no transaction.
//   cfg_we/cfg_index/cfg_wdata write element_width (index 0, which also
//            clears the pending bits) and the sign mode (index 1). Write only
//            while the block is idle.
// A taken byte enters the accumulator; its elements then enter the output register.
// Throughput: one element per cycle from the single output register while
//   out_elem is ready; for widths of 8 and above, one byte per cycle. A byte
//   completing several elements holds in_byte until its last one is emitted.
// Reset (rst, synchronous): pending bits cleared, element_width = 8,
//   sign extension off, no output pending.
// Receiver stall: the output register holds its transaction; the byte
//   channel stops once the pending elements of the current byte cannot move.
// ----------------------------------------------------------------------------
module bit_field_unpacker_core import bfu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bfu_byte_if.sink              in_byte,
  bfu_elem_if.source            out_elem
);

  // Configuration and stream state
  logic [WIDTH_W-1:0] elem_width;
  logic               sign_ext;
  logic [ACC_W-1:0]   acc;
  logic [WIDTH_W-1:0] pend;
  logic               eob_hold;
  logic [ACC_W-1:0]   acc_next;
  logic [WIDTH_W-1:0] pend_next;
  logic               eob_hold_next;

  // Output register
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_last;

  // Step logic
  logic [WIDTH_W-1:0] w_eff;
  logic [WIDTH_W-1:0] w_dec;
  logic               has_elem;
  logic               out_free;
  logic               emit;
  logic [WIDTH_W-1:0] pend_after;
  logic               emit_last;
  logic               accept;
  logic [VALUE_W-1:0] field_mask;
  logic [VALUE_W-1:0] field;
  logic [VALUE_W-1:0] elem;
  logic [ACC_W-1:0]   base_acc;
  logic [WIDTH_W-1:0] base_pend;
  logic [ACC_W-1:0]   merged_acc;
  logic [WIDTH_W-1:0] merged_pend;

  // Clamp the configured width into 1..W_CAP
  always_comb begin
    if (elem_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (elem_width > WIDTH_W'(W_CAP)) begin
      w_eff = WIDTH_W'(W_CAP);
    end else begin
      w_eff = elem_width;
    end
  end
  assign w_dec = w_eff - WIDTH_W'(1);

  // Emit when a full element is held and the output register can take it
  assign has_elem   = (pend >= w_eff);
  assign out_free   = !out_valid || out_elem.ready;
  assign emit       = has_elem && out_free;
  assign pend_after = pend - w_eff;
  assign emit_last  = (pend_after < w_eff);

  // Take a byte once nothing is left to emit after this cycle
  assign in_byte.ready = !has_elem || (emit && emit_last);
  assign accept        = in_byte.valid && in_byte.ready;

  // Cut the oldest element and extend it
  assign field_mask = {VALUE_W{1'b1}} >> (WIDTH_W'(VALUE_W) - w_eff);
  assign field      = acc[VALUE_W-1:0] & field_mask;
  assign elem       = (sign_ext && field[w_dec[4:0]]) ? (field | ~field_mask) : field;

  // State after the emission of this cycle
  always_comb begin
    if (emit && emit_last && eob_hold) begin
      base_acc  = '0;
      base_pend = '0;
    end else if (emit) begin
      base_acc  = acc >> w_eff;
      base_pend = pend_after;
    end else begin
      base_acc  = acc;
      base_pend = pend;
    end
  end

  // Merge an accepted byte above the pending bits
  assign merged_acc  = base_acc | (ACC_W'(in_byte.data_byte) << base_pend);
  assign merged_pend = base_pend + WIDTH_W'(BYTE_W);

  always_comb begin
    acc_next      = base_acc;
    pend_next     = base_pend;
    eob_hold_next = eob_hold && !(emit && emit_last);
    if (accept) begin
      if (in_byte.end_of_buffer && (merged_pend < w_eff)) begin
        // end of buffer with no element completed: drop everything
        acc_next      = '0;
        pend_next     = '0;
        eob_hold_next = 1'b0;
      end else begin
        acc_next      = merged_acc;
        pend_next     = merged_pend;
        eob_hold_next = in_byte.end_of_buffer;
      end
    end
  end

  // Configuration registers and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_width <= WIDTH_RESET;
      sign_ext   <= 1'b0;
      acc        <= '0;
      pend       <= '0;
      eob_hold   <= 1'b0;
    end else if (cfg_we && (cfg_index == REG_ELEMENT_WIDTH)) begin
      elem_width <= cfg_wdata[WIDTH_W-1:0];
      acc        <= '0;
      pend       <= '0;
      eob_hold   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_SIGN_EXT)) begin
        sign_ext <= cfg_wdata[0];
      end
      acc      <= acc_next;
      pend     <= pend_next;
      eob_hold <= eob_hold_next;
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_elem.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value <= elem;
      out_last  <= emit_last;
    end
  end

  assign out_elem.valid         = out_valid;
  assign out_elem.element_value = out_value;
  assign out_elem.last_of_byte  = out_last;

  // An end-of-buffer byte is only held while it still owes elements
  a_eob_owes_elem: assert property (@(posedge clk) disable iff (rst)
    eob_hold |-> has_elem)
    else $error("end-of-buffer held with no element pending");

  // Bits above the pending count are always clear
  a_acc_clean: assert property (@(posedge clk) disable iff (rst)
    (acc >> pend) == '0)
    else $error("accumulator holds bits above the pending count");

  // The last element of a byte leaves less than one element behind
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last && !accept && !cfg_we) |=> (pend < w_eff))
    else $error("full element left after last element of a byte");

  // A byte is only merged when no earlier element would be left behind
  a_merge_clear: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!has_elem || emit_last))
    else $error("byte taken while elements still pending");

endmodule
